// ===== design/rfcdec_pkg.sv =====
package rfcdec_pkg;

  // alphabet codes of base_select (code 3 behaves as base64)
  localparam logic [1:0] BASE16 = 2'd0;
  localparam logic [1:0] BASE32 = 2'd1;
  localparam logic [1:0] BASE64 = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_LENGTH   = 2'd2;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    SYM_DATA,
    SYM_PAD,
    SYM_BAD
  } sym_kind_t;

  typedef struct packed {
    sym_kind_t  kind;
    logic [5:0] value;
  } sym_t;

  // one decoded character's worth of output: bytes packed first-out in the top bits
  typedef struct packed {
    logic [39:0] data;
    logic [2:0]  nbytes;
    logic        last;
    logic [1:0]  status;
  } job_t;

  // head of the job queue as seen by the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } queue_head_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  function automatic sym_t sym16(input logic [7:0] c);
    sym_t       s;
    logic [7:0] u;
    logic [7:0] t;
    u = fold_upper(c);
    s.kind  = SYM_BAD;
    s.value = 6'd0;
    t = 8'd0;
    if (u >= 8'h30 && u <= 8'h39) begin
      t = u - 8'h30;
      s.kind = SYM_DATA;
    end else if (u >= 8'h41 && u <= 8'h46) begin
      t = u - 8'h41 + 8'd10;
      s.kind = SYM_DATA;
    end
    s.value = t[5:0];
    return s;
  endfunction

  function automatic sym_t sym32(input logic [7:0] c);
    sym_t       s;
    logic [7:0] u;
    logic [7:0] t;
    u = fold_upper(c);
    s.kind  = SYM_BAD;
    s.value = 6'd0;
    t = 8'd0;
    if (u >= 8'h41 && u <= 8'h5a) begin
      t = u - 8'h41;
      s.kind = SYM_DATA;
    end else if (u >= 8'h32 && u <= 8'h37) begin
      t = u - 8'h32 + 8'd26;
      s.kind = SYM_DATA;
    end else if (u == 8'h3d) begin
      s.kind = SYM_PAD;
    end
    s.value = t[5:0];
    return s;
  endfunction

  function automatic sym_t sym64(input logic [7:0] c);
    sym_t       s;
    logic [7:0] t;
    s.kind  = SYM_BAD;
    s.value = 6'd0;
    t = 8'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      t = c - 8'h41;
      s.kind = SYM_DATA;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      t = c - 8'h61 + 8'd26;
      s.kind = SYM_DATA;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      s.kind = SYM_DATA;
    end else if (c == 8'h2b) begin
      t = 8'd62;
      s.kind = SYM_DATA;
    end else if (c == 8'h2f) begin
      t = 8'd63;
      s.kind = SYM_DATA;
    end else if (c == 8'h3d) begin
      s.kind = SYM_PAD;
    end
    s.value = t[5:0];
    return s;
  endfunction

endpackage

// ===== design/rfc4648_stream_decoder.sv =====
// streaming rfc 4648 decoder: one character of base16, base32 or base64 text per beat
// in, decoded bytes out one per beat. the front end classifies a character and updates
// the group accumulator in the cycle it is accepted, so a new character can be taken
// every cycle while the four-entry job queue has room; each queued job then leaves the
// back end as one to five result beats at one beat per cycle while the consumer pops.
// sustained throughput is therefore set by the result port: a character that closes a
// base32 group yields five result beats, a base64 group three, a base16 pair one. the
// final result of a message carries end_of_message and the status (length error wins
// over invalid character); bytes already delivered before an error are not recalled and
// must be dropped by the consumer. base_select sits at byte address 0 of the apb port
// and must only be written between messages.
module rfc4648_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // character input
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_char,
  input  logic        last_char,
  // result output
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  data_byte,
  output logic        has_data,
  output logic [1:0]  status,
  output logic        end_of_message
);
  import rfcdec_pkg::*;

  logic        base_sel_hit;
  logic [1:0]  base_select;
  logic        in_valid;
  logic        job_push;
  job_t        job;
  queue_head_t head;
  logic        job_pop;

  // single register, word 0
  assign base_sel_hit = (paddr[2] == 1'b0);
  assign pready       = 1'b1;
  assign prdata       = base_sel_hit ? {30'd0, base_select} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_select <= BASE64;
    end else if (psel && penable && pwrite && base_sel_hit) begin
      base_select <= pwdata[1:0];
    end
  end

  // a character is taken only when its job is sure to fit in the queue
  assign in_valid = push && !full;

  rfcdec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .base_select (base_select),
    .in_valid    (in_valid),
    .text_char   (text_char),
    .last_char   (last_char),
    .job_push    (job_push),
    .job         (job)
  );

  // decouples character intake from result bursts
  rfcdec_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wr_job (job),
    .full   (full),
    .pop    (job_pop),
    .head   (head)
  );

  // serializes each job into result beats through an output register
  rfcdec_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .job_pop        (job_pop),
    .empty          (empty),
    .pop            (pop),
    .data_byte      (data_byte),
    .has_data       (has_data),
    .status         (status),
    .end_of_message (end_of_message)
  );

endmodule

// ===== design/rfcdec_front.sv =====
module rfcdec_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        base_select,
  input  logic              in_valid,
  input  logic [7:0]        text_char,
  input  logic              last_char,
  output logic              job_push,
  output rfcdec_pkg::job_t  job
);
  import rfcdec_pkg::*;

  logic [39:0] accumulator, accumulator_next;
  logic [2:0]  symbol_count, symbol_count_next;
  logic [2:0]  char_phase, char_phase_next;
  logic        pad_seen, pad_seen_next;
  logic [1:0]  error_code, error_code_next;

  sym_t        sym;
  logic [3:0]  group_len;
  logic [2:0]  phase_inc;
  logic [2:0]  cnt_inc;
  logic [39:0] acc_shift;
  logic        decoding;
  logic        group_done;
  logic [39:0] group_data;
  logic [2:0]  group_bytes;
  logic [39:0] acc_mid;
  logic [2:0]  cnt_mid;
  logic        pad_mid;
  logic [1:0]  err_mid;
  logic [1:0]  status;
  logic [39:0] tail_data;
  logic [2:0]  tail_bytes;

  always_comb begin
    unique case (base_select)
      BASE16: begin
        sym       = sym16(text_char);
        group_len = 4'd2;
        acc_shift = {accumulator[35:0], sym.value[3:0]};
      end
      BASE32: begin
        sym       = sym32(text_char);
        group_len = 4'd8;
        acc_shift = {accumulator[34:0], sym.value[4:0]};
      end
      default: begin
        sym       = sym64(text_char);
        group_len = 4'd4;
        acc_shift = {accumulator[33:0], sym.value};
      end
    endcase
  end

  always_comb begin
    phase_inc = char_phase + 3'd1;
    char_phase_next = ({1'b0, phase_inc} >= group_len) ? 3'd0 : phase_inc;

    decoding = !pad_seen && (error_code == ST_OK);
    cnt_inc  = symbol_count + 3'd1;
    group_done = decoding && (sym.kind == SYM_DATA)
                 && ((cnt_inc == 3'd0) || ({1'b0, cnt_inc} >= group_len));

    // complete group: bytes come from the low bits of the accumulator
    unique case (base_select)
      BASE16: begin
        group_data  = {acc_shift[7:0], 32'd0};
        group_bytes = 3'd1;
      end
      BASE32: begin
        group_data  = acc_shift;
        group_bytes = 3'd5;
      end
      default: begin
        group_data  = {acc_shift[23:0], 16'd0};
        group_bytes = 3'd3;
      end
    endcase

    acc_mid = accumulator;
    cnt_mid = symbol_count;
    pad_mid = pad_seen;
    err_mid = error_code;
    if (decoding) begin
      unique case (sym.kind)
        SYM_DATA: begin
          acc_mid = group_done ? 40'd0 : acc_shift;
          cnt_mid = group_done ? 3'd0 : cnt_inc;
        end
        SYM_PAD: pad_mid = 1'b1;
        default: err_mid = ST_BAD_CHAR;
      endcase
    end

    status = (char_phase_next != 3'd0) ? ST_LENGTH : err_mid;

    // leftover symbols at end of message
    tail_data  = 40'd0;
    tail_bytes = 3'd0;
    if (status == ST_OK) begin
      if (base_select == BASE32) begin
        case (cnt_mid)
          3'd7: begin tail_data = {acc_mid[34:3], 8'd0};  tail_bytes = 3'd4; end
          3'd5: begin tail_data = {acc_mid[24:1], 16'd0}; tail_bytes = 3'd3; end
          3'd4: begin tail_data = {acc_mid[19:4], 24'd0}; tail_bytes = 3'd2; end
          3'd2: begin tail_data = {acc_mid[9:2], 32'd0};  tail_bytes = 3'd1; end
          default: ;
        endcase
      end else if (base_select != BASE16) begin
        case (cnt_mid)
          3'd3: begin tail_data = {acc_mid[17:2], 24'd0}; tail_bytes = 3'd2; end
          3'd2: begin tail_data = {acc_mid[11:4], 32'd0}; tail_bytes = 3'd1; end
          default: ;
        endcase
      end
    end

    job.last   = last_char;
    job.status = last_char ? status : ST_OK;
    if (group_done) begin
      job.data   = group_data;
      job.nbytes = group_bytes;
    end else if (last_char) begin
      job.data   = tail_data;
      job.nbytes = tail_bytes;
    end else begin
      job.data   = 40'd0;
      job.nbytes = 3'd0;
    end
    job_push = in_valid && ((job.nbytes != 3'd0) || last_char);

    accumulator_next  = last_char ? 40'd0 : acc_mid;
    symbol_count_next = last_char ? 3'd0 : cnt_mid;
    pad_seen_next     = last_char ? 1'b0 : pad_mid;
    error_code_next   = last_char ? ST_OK : err_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= 40'd0;
      symbol_count <= 3'd0;
      char_phase   <= 3'd0;
      pad_seen     <= 1'b0;
      error_code   <= ST_OK;
    end else if (in_valid) begin
      accumulator  <= accumulator_next;
      symbol_count <= symbol_count_next;
      char_phase   <= last_char ? 3'd0 : char_phase_next;
      pad_seen     <= pad_seen_next;
      error_code   <= error_code_next;
    end
  end

endmodule

// ===== design/rfcdec_queue.sv =====
module rfcdec_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  rfcdec_pkg::job_t        wr_job,
  output logic                    full,
  input  logic                    pop,
  output rfcdec_pkg::queue_head_t head
);
  import rfcdec_pkg::*;

  job_t                entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;

  assign full       = (count == (QueuePtrW+1)'(QueueDepth));
  assign head.valid = (count != '0);
  assign head.job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QueuePtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QueuePtrW+1)'(1);
        2'b01:   count <= count - (QueuePtrW+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

// ===== design/rfcdec_back.sv =====
module rfcdec_back (
  input  logic                    clk,
  input  logic                    rst,
  input  rfcdec_pkg::queue_head_t head,
  output logic                    job_pop,
  output logic                    empty,
  input  logic                    pop,
  output logic [7:0]              data_byte,
  output logic                    has_data,
  output logic [1:0]              status,
  output logic                    end_of_message
);
  import rfcdec_pkg::*;

  logic [2:0] idx;
  logic       out_valid;
  logic       load;
  logic [2:0] nres;
  logic       is_final;
  logic [7:0] sel_byte;
  logic       sel_has;

  always_comb begin
    case (idx)
      3'd0:    sel_byte = head.job.data[39:32];
      3'd1:    sel_byte = head.job.data[31:24];
      3'd2:    sel_byte = head.job.data[23:16];
      3'd3:    sel_byte = head.job.data[15:8];
      3'd4:    sel_byte = head.job.data[7:0];
      default: sel_byte = 8'd0;
    endcase
    sel_has  = (head.job.nbytes != 3'd0);
    nres     = sel_has ? head.job.nbytes : 3'd1;
    is_final = (idx == nres - 3'd1);
    load     = head.valid && (!out_valid || pop);
    job_pop  = load && is_final;
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_final ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_byte      <= sel_has ? sel_byte : 8'd0;
      has_data       <= sel_has;
      status         <= (is_final && head.job.last) ? head.job.status : ST_OK;
      end_of_message <= is_final && head.job.last;
    end
  end

endmodule

// ===== tb/sv/tb_rfc4648_stream_decoder.sv =====
`timescale 1ns / 1ps

module tb_rfc4648_stream_decoder;
  import rfcdec_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int SettleCycles = 12;
  localparam int IdlePct = 24;
  localparam logic [2:0] AddrBaseSel = 3'd0;
  localparam logic [2:0] AddrUnused = 3'd4;
  // symbol codes of the predictor's own character lookup
  localparam int PadSym = 64;
  localparam int BadSym = -1;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic [1:0] st;
    logic       eom;
  } beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } char_beat_t;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic [7:0] text_char = 8'd0;
  logic last_char = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] data_byte;
  logic has_data;
  logic [1:0] status;
  logic end_of_message;

  rfc4648_stream_decoder dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .push(push),
    .full(full),
    .text_char(text_char),
    .last_char(last_char),
    .empty(empty),
    .pop(pop),
    .data_byte(data_byte),
    .has_data(has_data),
    .status(status),
    .end_of_message(end_of_message)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // decoder state as the testbench sees it
  logic [1:0]  base_sel = BASE64;
  logic [39:0] acc = 40'd0;
  logic [2:0]  nsym = 3'd0;
  logic [2:0]  phase = 3'd0;
  logic        padded = 1'b0;
  logic        bad_char = 1'b0;

  beat_t      bytes_due[$];   // decoded beats still owed by the block
  char_beat_t char_feed[$];   // characters waiting for the driver
  int fed = 0;
  int taken = 0;
  int bad = 0;
  int cycles = 0;
  logic calm = 1'b0;          // no idling on either side while set
  logic beat_in = 1'b0;       // a character was accepted at the last rising edge
  char_beat_t nxt;

  // character to symbol value in the given alphabet; selector 3 acts as base64
  function automatic int sym_of(input logic [7:0] c, input logic [1:0] b);
    logic [7:0] u;
    u = c;
    if (b == BASE16 || b == BASE32) begin
      if (c >= "a" && c <= "z") u = c - 8'd32;
    end
    if (b == BASE16) begin
      if (u >= "0" && u <= "9") return u - "0";
      if (u >= "A" && u <= "F") return u - "A" + 10;
      return BadSym;
    end
    if (b == BASE32) begin
      if (u >= "A" && u <= "Z") return u - "A";
      if (u >= "2" && u <= "7") return u - "2" + 26;
      if (u == "=") return PadSym;
      return BadSym;
    end
    if (u >= "A" && u <= "Z") return u - "A";
    if (u >= "a" && u <= "z") return u - "a" + 26;
    if (u >= "0" && u <= "9") return u - "0" + 52;
    if (u == "+") return 62;
    if (u == "/") return 63;
    if (u == "=") return PadSym;
    return BadSym;
  endfunction

  function automatic beat_t byte_beat(input logic [39:0] v);
    beat_t r;
    r.data = v[7:0];
    r.has = 1'b1;
    r.st = ST_OK;
    r.eom = 1'b0;
    return r;
  endfunction

  // works out the beats that one accepted character causes
  task automatic decode_char(input logic [7:0] c, input logic fin);
    int bits, grp, chars, s;
    logic [1:0] st;
    beat_t outq[$];
    beat_t blank;
    if (base_sel == BASE16) begin
      bits = 4; grp = 2; chars = 2;
    end else if (base_sel == BASE32) begin
      bits = 5; grp = 8; chars = 8;
    end else begin
      bits = 6; grp = 4; chars = 4;
    end
    phase = phase + 3'd1;
    if (phase >= chars) phase = 3'd0;
    if (!padded && !bad_char) begin
      s = sym_of(c, base_sel);
      if (s == PadSym) begin
        padded = 1'b1;
      end else if (s == BadSym) begin
        bad_char = 1'b1;
      end else begin
        acc = (acc << bits) | s;
        nsym = nsym + 3'd1;
        // group closes on wrap too, and early if the selector shrank mid-message
        if (nsym == 3'd0 || nsym >= grp) begin
          if (base_sel == BASE16) begin
            outq.push_back(byte_beat(acc));
          end else if (base_sel == BASE32) begin
            for (int k = 32; k >= 0; k -= 8) outq.push_back(byte_beat(acc >> k));
          end else begin
            for (int k = 16; k >= 0; k -= 8) outq.push_back(byte_beat(acc >> k));
          end
          acc = 40'd0;
          nsym = 3'd0;
        end
      end
    end
    if (fin) begin
      // length error wins over a bad character
      st = (phase != 3'd0) ? ST_LENGTH : (bad_char ? ST_BAD_CHAR : ST_OK);
      if (st == ST_OK) begin
        if (base_sel == BASE32) begin
          case (nsym)
            3'd7: begin
              outq.push_back(byte_beat(acc >> 27));
              outq.push_back(byte_beat(acc >> 19));
              outq.push_back(byte_beat(acc >> 11));
              outq.push_back(byte_beat(acc >> 3));
            end
            3'd5: begin
              outq.push_back(byte_beat(acc >> 17));
              outq.push_back(byte_beat(acc >> 9));
              outq.push_back(byte_beat(acc >> 1));
            end
            3'd4: begin
              outq.push_back(byte_beat(acc >> 12));
              outq.push_back(byte_beat(acc >> 4));
            end
            3'd2: outq.push_back(byte_beat(acc >> 2));
            default: ;
          endcase
        end else if (base_sel != BASE16) begin
          case (nsym)
            3'd3: begin
              outq.push_back(byte_beat(acc >> 10));
              outq.push_back(byte_beat(acc >> 2));
            end
            3'd2: outq.push_back(byte_beat(acc >> 4));
            default: ;
          endcase
        end
      end
      // end of message with nothing to deliver still gets one empty beat
      if (outq.size() == 0) begin
        blank = '0;
        outq.push_back(blank);
      end
      outq[outq.size() - 1].st = st;
      outq[outq.size() - 1].eom = 1'b1;
      acc = 40'd0;
      nsym = 3'd0;
      phase = 3'd0;
      padded = 1'b0;
      bad_char = 1'b0;
    end
    foreach (outq[i]) bytes_due.push_back(outq[i]);
  endtask

  // input side: note accepted characters and predict their output
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      beat_in <= 1'b0;
    end else begin
      beat_in <= push && !full;
      if (push && !full) begin
        taken <= taken + 1;
        decode_char(text_char, last_char);
      end
    end
  end

  // input side: present the next character once the previous one is gone
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || beat_in) begin
      if (char_feed.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        nxt = char_feed.pop_front();
        push <= 1'b1;
        text_char <= nxt.ch;
        last_char <= nxt.fin;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result side: random back pressure
  always @(negedge clk) begin
    pop <= !rst && (calm || $urandom_range(99) >= IdlePct);
  end

  // result side: compare every popped beat with the oldest prediction
  always @(posedge clk) begin
    beat_t want;
    if (!rst && pop && !empty) begin
      if (bytes_due.size() == 0) begin
        $display("%0t: unexpected beat, data_byte %h has_data %b status %0d eom %b",
                 $time, data_byte, has_data, status, end_of_message);
        bad = bad + 1;
      end else begin
        want = bytes_due.pop_front();
        if (data_byte !== want.data) begin
          $display("%0t: data_byte expected %h actual %h", $time, want.data, data_byte);
          bad = bad + 1;
        end
        if (has_data !== want.has) begin
          $display("%0t: has_data expected %b actual %b", $time, want.has, has_data);
          bad = bad + 1;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          bad = bad + 1;
        end
        if (end_of_message !== want.eom) begin
          $display("%0t: end_of_message expected %b actual %b", $time, want.eom,
                   end_of_message);
          bad = bad + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("tb_rfc4648_stream_decoder failed");
      $finish;
    end
  end

  task automatic feed_char(input logic [7:0] ch, input logic fin);
    char_beat_t cb;
    cb.ch = ch;
    cb.fin = fin;
    char_feed.push_back(cb);
    fed = fed + 1;
  endtask

  task automatic feed_text(input string s, input logic fin);
    for (int k = 0; k < s.len(); k++) feed_char(s[k], fin && (k == s.len() - 1));
  endtask

  // wait for every character to go in and every predicted beat to come out,
  // then let the pipe settle while idle
  task automatic drain();
    while (taken != fed || bytes_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] wd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= wd;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == AddrBaseSel) base_sel = wd[1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: prdata expected %h actual %h", $time, want, prdata);
      bad = bad + 1;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // a random symbol of the alphabet, letters in either case where case is folded
  function automatic logic [7:0] sym_char(input logic [1:0] b);
    string abc;
    logic [7:0] ch;
    if (b == BASE16) begin
      abc = "0123456789ABCDEF";
      ch = abc[$urandom_range(15)];
    end else if (b == BASE32) begin
      abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
      ch = abc[$urandom_range(31)];
    end else begin
      abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      return abc[$urandom_range(63)];
    end
    if (ch >= "A" && ch <= "Z" && $urandom_range(1)) ch = ch + 8'd32;
    return ch;
  endfunction

  // mostly well-formed messages with random content; some broken, some noise
  task automatic queue_message(input logic [1:0] b);
    int roll, glen, nsyms, total, bad_at;
    logic [7:0] ch;
    roll = $urandom_range(99);
    if (roll < 12) begin
      // raw noise over the whole byte range
      total = $urandom_range(1, 9);
      for (int k = 0; k < total; k++) feed_char(8'($urandom_range(255)), k == total - 1);
    end else begin
      glen = (b == BASE16) ? 2 : (b == BASE32) ? 8 : 4;
      nsyms = $urandom_range(1, 3 * glen - 1);
      total = ((nsyms + glen - 1) / glen) * glen;
      if (b == BASE16) nsyms = total;
      // missing padding gives a length error
      if (roll >= 22 && roll < 30) total = nsyms;
      bad_at = (roll >= 12 && roll < 22) ? $urandom_range(0, total - 1) : -1;
      for (int k = 0; k < total; k++) begin
        if (k == bad_at) begin
          do ch = 8'($urandom_range(255)); while (sym_of(ch, b) != BadSym);
        end else if (k < nsyms) begin
          ch = sym_char(b);
        end else if (roll >= 95) begin
          // characters after the pad are counted but not decoded
          ch = (k == nsyms) ? 8'h3d : 8'($urandom_range(255));
        end else begin
          ch = "=";
        end
        feed_char(ch, k == total - 1);
      end
    end
  endtask

  initial begin
    logic [1:0] plan[7];
    logic [31:0] wd;
    int stop_at;
    plan = '{BASE64, BASE32, BASE16, 2'd3, BASE32, BASE64, BASE16};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset selector is base64
    apb_read_check(AddrBaseSel, {30'd0, BASE64});
    feed_text("+/9z", 1'b1);
    // pad stops decoding, the character after it only counts toward length
    feed_text("TQ=x", 1'b1);
    // bad characters at both byte extremes
    feed_char(8'h00, 1'b0);
    feed_text("AB", 1'b0);
    feed_char(8'hff, 1'b1);
    // lone character: length error with no bytes
    feed_text("Q", 1'b1);
    drain();

    apb_write(AddrBaseSel, {30'd0, BASE16});
    // case folding, and pad is invalid in base16
    feed_text("fF09", 1'b1);
    feed_text("=a", 1'b1);
    drain();

    apb_write(AddrBaseSel, {30'd0, BASE32});
    feed_text("MZXW6===", 1'b1);
    drain();

    // unused selector code, then a write to a register that does not exist
    apb_write(AddrBaseSel, 32'hffff_ffff);
    apb_read_check(AddrBaseSel, 32'd3);
    apb_write(AddrUnused, 32'd0);
    apb_read_check(AddrBaseSel, 32'd3);

    // selector changed in the middle of a message
    apb_write(AddrBaseSel, {30'd0, BASE32});
    feed_text("MZX", 1'b0);
    drain();
    apb_write(AddrBaseSel, {30'd0, BASE16});
    feed_text("AB", 1'b1);
    drain();

    // random phases, one per selector setting
    foreach (plan[p]) begin
      wd = $urandom;
      wd[1:0] = plan[p];
      apb_write(AddrBaseSel, wd);
      apb_read_check(AddrBaseSel, {30'd0, plan[p]});
      calm = (p == 2);
      stop_at = fed + 40;
      while (fed < stop_at) queue_message(plan[p]);
      drain();
    end
    calm = 1'b0;

    if (bad == 0 && bytes_due.size() == 0) begin
      $display("tb_rfc4648_stream_decoder passed");
    end else begin
      $display("tb_rfc4648_stream_decoder failed");
    end
    $finish;
  end

endmodule
